/* rtl/audio_silence_link_gate_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the audio silence link gate checker
// ----------------------------------------------------------------------------
`ifndef AUDIO_SILENCE_LINK_GATE_CORE_ASSERT_SVH
`define AUDIO_SILENCE_LINK_GATE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("audio silence link gate check failed");

// next-cycle implication, sampled on clock, off during reset
`define ASG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("audio silence link gate check failed");

`endif

/* rtl/asg_pkg.sv */
// ----------------------------------------------------------------------------
// asg_pkg
// Shared types and constants of the audio silence link gate.
// ----------------------------------------------------------------------------
package asg_pkg;

   localparam int MAX_CHANNELS_DEF     = 8;
   localparam int MAX_BLOCK_FRAMES_DEF = 4096;
   localparam int QUEUE_DEPTH          = 2;

   // operation codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_SHORT  = 2'd1;
   localparam logic [1:0] OP_LOST   = 2'd2;

   // sample width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;
   localparam logic [1:0] WIDTH_32 = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SAMPLE_BITS   = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_FRAMES  = 2'd2;
   localparam logic [1:0] CSR_SILENCE_LIMIT = 2'd3;

   localparam logic [1:0]  SAMPLE_BITS_RST   = WIDTH_16;
   localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;
   localparam logic [12:0] BLOCK_FRAMES_RST  = 13'd128;
   localparam logic [15:0] SILENCE_LIMIT_RST = 16'd1875;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic        connect_event;
      logic        disconnect_event;
      logic        forward_block;
      logic        block_silent;
      logic [16:0] silence_count;
      logic        halted;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  sample_bits_code;
      logic [3:0]  channel_count;
      logic [12:0] block_frames;
      logic [15:0] silence_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      EV_BLOCK = 2'd0,
      EV_SHORT = 2'd1,
      EV_LOST  = 2'd2
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic        silent;
   } event_type;

endpackage

/* rtl/asg_front.sv */
// ----------------------------------------------------------------------------
// asg_front
// Tracks frame and channel position, compares each sample against the first
// frame of its block and emits one event per finished block or fault.
// ----------------------------------------------------------------------------
module asg_front #(
   parameter int MaxChannels    = asg_pkg::MAX_CHANNELS_DEF,
   parameter int MaxBlockFrames = asg_pkg::MAX_BLOCK_FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  asg_pkg::req_type   item,
   input  asg_pkg::cfg_type   cfg,
   input  logic               cfg_write,
   output logic               ev_valid,
   output asg_pkg::event_type ev
);
   import asg_pkg::*;

   localparam int ChW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
   localparam int FrW = $clog2(MaxBlockFrames);

   logic [31:0]    store_ff [MaxChannels];
   logic [ChW-1:0] chan_pos_ff, chan_pos_in, chan_last;
   logic [FrW-1:0] frame_pos_ff, frame_pos_in, frame_last;
   logic           mismatch_ff, mismatch_in;
   logic           stopped_ff, stopped_in;
   logic [31:0]    mask;
   logic [31:0]    sample_masked;
   logic           mismatch_now;
   logic           never_silent;
   logic           take;

   always_comb begin
      unique case (cfg.sample_bits_code)
         WIDTH_8:  mask = 32'h0000_00FF;
         WIDTH_16: mask = 32'h0000_FFFF;
         WIDTH_24: mask = 32'h00FF_FFFF;
         WIDTH_32: mask = 32'hFFFF_FFFF;
         default:  mask = 32'hFFFF_FFFF;
      endcase
   end

   // clamp the channel and frame counts to 1..max, kept as last index
   always_comb begin
      if (cfg.channel_count == '0) begin
         chan_last = '0;
      end else if (32'(cfg.channel_count) > 32'(MaxChannels)) begin
         chan_last = ChW'(MaxChannels - 1);
      end else begin
         chan_last = ChW'(cfg.channel_count - 4'd1);
      end
      if (cfg.block_frames == '0) begin
         frame_last = '0;
      end else if (32'(cfg.block_frames) > 32'(MaxBlockFrames)) begin
         frame_last = FrW'(MaxBlockFrames - 1);
      end else begin
         frame_last = FrW'(cfg.block_frames - 13'd1);
      end
   end

   assign never_silent  = (cfg.sample_bits_code == WIDTH_24) ||
                          !(32'(frame_last) > 32'(chan_last));
   assign sample_masked = 32'(item.sample_value) & mask;
   assign mismatch_now  = mismatch_ff ||
                          ((frame_pos_ff != '0) && (store_ff[chan_pos_ff] != sample_masked));
   assign take          = item_valid && !stopped_ff;

   always_comb begin
      chan_pos_in  = chan_pos_ff;
      frame_pos_in = frame_pos_ff;
      mismatch_in  = mismatch_ff;
      stopped_in   = stopped_ff;
      ev_valid     = 1'b0;
      ev.kind      = EV_BLOCK;
      ev.silent    = 1'b0;
      if (cfg_write) begin
         chan_pos_in  = '0;
         frame_pos_in = '0;
         mismatch_in  = 1'b0;
      end else if (take) begin
         unique case (item.operation)
            OP_SAMPLE: begin
               mismatch_in = mismatch_now;
               if (chan_pos_ff != chan_last) begin
                  chan_pos_in = chan_pos_ff + ChW'(1);
               end else begin
                  chan_pos_in = '0;
                  if (frame_pos_ff != frame_last) begin
                     frame_pos_in = frame_pos_ff + FrW'(1);
                  end else begin
                     frame_pos_in = '0;
                     mismatch_in  = 1'b0;
                     ev_valid     = 1'b1;
                     ev.kind      = EV_BLOCK;
                     ev.silent    = !mismatch_now && !never_silent;
                  end
               end
            end
            OP_SHORT: begin
               chan_pos_in  = '0;
               frame_pos_in = '0;
               mismatch_in  = 1'b0;
               ev_valid     = 1'b1;
               ev.kind      = EV_SHORT;
            end
            OP_LOST: begin
               chan_pos_in  = '0;
               frame_pos_in = '0;
               mismatch_in  = 1'b0;
               stopped_in   = 1'b1;
               ev_valid     = 1'b1;
               ev.kind      = EV_LOST;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff  <= '0;
         frame_pos_ff <= '0;
         mismatch_ff  <= 1'b0;
         stopped_ff   <= 1'b0;
      end else begin
         chan_pos_ff  <= chan_pos_in;
         frame_pos_ff <= frame_pos_in;
         mismatch_ff  <= mismatch_in;
         stopped_ff   <= stopped_in;
      end
   end

   // capture the reference frame
   always_ff @(posedge clock) begin
      if (take && !cfg_write && (item.operation == OP_SAMPLE) && (frame_pos_ff == '0)) begin
         store_ff[chan_pos_ff] <= sample_masked;
      end
   end

endmodule

/* rtl/asg_queue.sv */
// ----------------------------------------------------------------------------
// asg_queue
// Short event queue between the classifier and the link state stage.
// ----------------------------------------------------------------------------
module asg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  asg_pkg::event_type push_word,
   output logic               q_full,
   input  logic               pop_take,
   output asg_pkg::event_type pop_word,
   output logic               q_empty
);
   import asg_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   event_type     mem_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign q_full   = (count_ff == (QW+1)'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign do_push  = push_valid && !q_full;
   assign do_pop   = pop_take && !q_empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* rtl/asg_back.sv */
// ----------------------------------------------------------------------------
// asg_back
// Runs the silent-block counter and link state for each event and holds the
// result word in an output register.
// ----------------------------------------------------------------------------
module asg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        silence_limit,
   input  logic               ev_avail,
   input  asg_pkg::event_type ev,
   output logic               ev_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output asg_pkg::rsp_type   rsp_word
);
   import asg_pkg::*;

   logic        out_valid_ff, out_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [16:0] count_ff, count_in;
   logic        connected_ff, connected_in;
   logic        halted_ff, halted_in;
   logic [16:0] limit;
   logic [16:0] count_mid;

   assign limit     = {1'b0, silence_limit};
   assign ev_take   = ev_avail && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      count_in     = count_ff;
      connected_in = connected_ff;
      halted_in    = halted_ff;
      rsp_in       = rsp_ff;
      count_mid    = count_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (ev_take) begin
         out_valid_in = 1'b1;
         rsp_in       = '0;
         unique case (ev.kind)
            EV_BLOCK: begin
               if (ev.silent) begin
                  count_mid = (count_ff < limit) ? count_ff + 17'd1 : count_ff;
               end else begin
                  count_mid = '0;
               end
               count_in = count_mid;
               if (connected_ff && (count_mid == limit)) begin
                  rsp_in.disconnect_event = 1'b1;
                  count_in                = count_mid + 17'd1;
                  connected_in            = 1'b0;
               end else if (!connected_ff && (count_mid < limit)) begin
                  rsp_in.connect_event = 1'b1;
                  connected_in         = 1'b1;
               end
               rsp_in.forward_block = (count_in < limit);
               rsp_in.block_silent  = ev.silent;
            end
            EV_SHORT, EV_LOST: begin
               rsp_in.disconnect_event = connected_ff;
               connected_in            = 1'b0;
               if (ev.kind == EV_LOST) begin
                  halted_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rsp_in.silence_count = count_in;
         rsp_in.halted        = halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         connected_ff <= 1'b0;
         halted_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         connected_ff <= connected_in;
         halted_ff    <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

/* rtl/audio_silence_link_gate_core.sv */
// ----------------------------------------------------------------------------
// audio_silence_link_gate_core
// Silence detector and sink link gate for blocks of interleaved samples.
// ----------------------------------------------------------------------------
// One word is accepted per clock while full is low and results leave at one
// per clock while pop is high. A result for the sample that closes its block
// (or the fault word) leaves the combinational front classifier into the
// event queue and reaches the rsp ports from the link state stage output
// register. The rate is set by the front's combinational compare of each
// sample against the first-frame register file. Every word pushed after a
// device-lost word is taken and dropped until reset. Configuration writes
// restart the block in progress and must be made while the block is idle.
// ----------------------------------------------------------------------------
module audio_silence_link_gate_core #(
   parameter int MaxChannels    = asg_pkg::MAX_CHANNELS_DEF,
   parameter int MaxBlockFrames = asg_pkg::MAX_BLOCK_FRAMES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  asg_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output asg_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import asg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      item_valid;
   logic      ev_valid;
   event_type ev_word;
   logic      q_empty;
   event_type q_word;
   logic      q_take;

   assign item_valid = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_BITS:   cfg_in.sample_bits_code = csr_wdata[1:0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count    = csr_wdata[3:0];
            CSR_BLOCK_FRAMES:  cfg_in.block_frames     = csr_wdata[12:0];
            CSR_SILENCE_LIMIT: cfg_in.silence_limit    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_bits_code <= SAMPLE_BITS_RST;
         cfg_ff.channel_count    <= CHANNEL_COUNT_RST;
         cfg_ff.block_frames     <= BLOCK_FRAMES_RST;
         cfg_ff.silence_limit    <= SILENCE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asg_front #(
      .MaxChannels    (MaxChannels),
      .MaxBlockFrames (MaxBlockFrames)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (req_data),
      .cfg        (cfg_ff),
      .cfg_write  (csr_we),
      .ev_valid   (ev_valid),
      .ev         (ev_word)
   );

   asg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ev_valid),
      .push_word  (ev_word),
      .q_full     (full),
      .pop_take   (q_take),
      .pop_word   (q_word),
      .q_empty    (q_empty)
   );

   asg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .silence_limit (cfg_ff.silence_limit),
      .ev_avail      (!q_empty),
      .ev            (q_word),
      .ev_take       (q_take),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_word      (rsp_data)
   );

endmodule

/* rtl/asg_checker.sv */
// ----------------------------------------------------------------------------
// asg_checker
// Port-level checks of the audio silence link gate result stream.
// ----------------------------------------------------------------------------
`include "audio_silence_link_gate_core_assert.svh"

module asg_checker (
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input asg_pkg::rsp_type rsp_data
);

   // hold a waiting result word
   `ASG_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_data))

   `ASG_ASSERT_NOW(a_conn_disc_excl, !empty, !(rsp_data.connect_event && rsp_data.disconnect_event))

   `ASG_ASSERT_NOW(a_conn_forwards, !empty && rsp_data.connect_event, rsp_data.forward_block)

   // a lost device ends with a bare fault word
   `ASG_ASSERT_NOW(a_halt_word, !empty && rsp_data.halted && !$past(rsp_data.halted), !rsp_data.connect_event && !rsp_data.forward_block && !rsp_data.block_silent)

endmodule

bind audio_silence_link_gate_core asg_checker u_asg_checker (.*);

/* tb/sv/audio_silence_link_gate_core_tb.sv */
// ----------------------------------------------------------------------------
// audio_silence_link_gate_core_tb
// Drives blocks of interleaved samples, short reads and a final device loss
// through the gate under bursty input and a stalling result side. Every
// result is checked against a cycle-free model of the silence counter and
// link state or a directed golden word. The run opens with a short directed
// table, then steps through register settings that include zero counts, an
// oversized channel count and both ends of the silence limit.
// ----------------------------------------------------------------------------
module audio_silence_link_gate_core_tb;
   import asg_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_type      word;
      logic [1:0]   csr_idx;
      logic [15:0]  csr_val;
      logic         typed;
      rsp_type      golden;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // model state
   cfg_type     gate_cfg;
   logic [31:0] frame_ref [MAX_CHANNELS_DEF];
   int          frame_pos;
   int          chan_pos;
   logic        diff_seen;
   logic [16:0] silent_run;
   logic        linked;
   logic        halted_flag;

   rsp_type     gate_expect_q [$];
   stim_row_type dir_rows [$];

   int          burst_left = 0;
   int          words_in = 0;
   int          results_checked = 0;
   int          reg_writes = 0;
   int          mismatches = 0;
   int          connects = 0;
   int          disconnects = 0;
   int          silent_seen = 0;
   logic [15:0] pop_tick = '0;
   int          pop_mode = 0;

   audio_silence_link_gate_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 800000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int active_channels();
      if (gate_cfg.channel_count == 0) return 1;
      if (gate_cfg.channel_count > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
      return int'(gate_cfg.channel_count);
   endfunction

   function automatic int active_frames();
      if (gate_cfg.block_frames == 0) return 1;
      if (gate_cfg.block_frames > MAX_BLOCK_FRAMES_DEF) return MAX_BLOCK_FRAMES_DEF;
      return int'(gate_cfg.block_frames);
   endfunction

   function automatic logic [31:0] width_mask();
      case (gate_cfg.sample_bits_code)
         WIDTH_8:  return 32'h0000_00FF;
         WIDTH_16: return 32'h0000_FFFF;
         WIDTH_24: return 32'h00FF_FFFF;
         default:  return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Advance the gate model by one word; return 1 when the word yields a result.
   function automatic bit gate_predict(input req_type w, output rsp_type r);
      logic [31:0] v;
      logic [16:0] lim;
      logic        closing_silent;
      r = '0;
      if (halted_flag || w.operation == OP_UNUSED) return 1'b0;
      lim = {1'b0, gate_cfg.silence_limit};
      if (w.operation == OP_SAMPLE) begin
         v = w.sample_value & width_mask();
         if (frame_pos == 0) begin
            frame_ref[chan_pos] = v;
         end else if (frame_ref[chan_pos] != v) begin
            diff_seen = 1'b1;
         end
         chan_pos++;
         if (chan_pos < active_channels()) return 1'b0;
         chan_pos = 0;
         frame_pos++;
         if (frame_pos < active_frames()) return 1'b0;
         closing_silent = !diff_seen && gate_cfg.sample_bits_code != WIDTH_24
                          && active_frames() > active_channels();
         frame_pos = 0;
         diff_seen = 1'b0;
         if (closing_silent) begin
            if (silent_run < lim) silent_run++;
         end else begin
            silent_run = '0;
         end
         if (linked && silent_run == lim) begin
            r.disconnect_event = 1'b1;
            silent_run++;
            linked = 1'b0;
         end
         if (!linked && silent_run < lim) begin
            r.connect_event = 1'b1;
            linked = 1'b1;
         end
         r.forward_block = silent_run < lim;
         r.block_silent = closing_silent;
      end else begin
         if (linked) begin
            r.disconnect_event = 1'b1;
            linked = 1'b0;
         end
         frame_pos = 0;
         chan_pos = 0;
         diff_seen = 1'b0;
         if (w.operation == OP_LOST) halted_flag = 1'b1;
      end
      r.silence_count = silent_run;
      r.halted = halted_flag;
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h0000_007F;
         5:       return 32'hFFFF_FF80;
         6:       return 32'hFFFF_8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type word_row(input logic [1:0] op, input logic [31:0] v);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.word.operation = op;
      row.word.sample_value = v;
      return row;
   endfunction

   function automatic stim_row_type golden_row(input logic [1:0] op, input logic [31:0] v,
                                               input rsp_type golden);
      stim_row_type row;
      row = word_row(op, v);
      row.typed = 1'b1;
      row.golden = golden;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [15:0] v);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = v;
      return row;
   endfunction

   task automatic note_mismatch(input string what, input rsp_type exp_r, input rsp_type got_r);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: exp conn=%0b disc=%0b fwd=%0b silent=%0b count=%0d halted=%0b",
                  what, exp_r.connect_event, exp_r.disconnect_event, exp_r.forward_block,
                  exp_r.block_silent, exp_r.silence_count, exp_r.halted);
         $display("   got conn=%0b disc=%0b fwd=%0b silent=%0b count=%0d halted=%0b",
                  got_r.connect_event, got_r.disconnect_event, got_r.forward_block,
                  got_r.block_silent, got_r.silence_count, got_r.halted);
      end
   endtask

   // Push one word in bursts; predict on acceptance.
   task automatic send_word(input req_type w, input logic typed, input rsp_type golden);
      rsp_type predicted;
      int      gap;
      csr_we <= 1'b0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      words_in++;
      if (gate_predict(w, predicted)) gate_expect_q.push_back(typed ? golden : predicted);
   endtask

   // Hold input until every result is out and the pipe has emptied.
   task automatic settle_gate();
      push <= 1'b0;
      csr_we <= 1'b0;
      while (gate_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      logic [15:0] keep;
      keep = 16'hFFFF;
      case (idx)
         CSR_SAMPLE_BITS: begin
            keep = 16'h0003;
            gate_cfg.sample_bits_code = value[1:0];
         end
         CSR_CHANNEL_COUNT: begin
            keep = 16'h000F;
            gate_cfg.channel_count = value[3:0];
         end
         CSR_BLOCK_FRAMES: begin
            keep = 16'h1FFF;
            gate_cfg.block_frames = value[12:0];
         end
         CSR_SILENCE_LIMIT: begin
            gate_cfg.silence_limit = value;
         end
      endcase
      frame_pos = 0;
      chan_pos = 0;
      diff_seen = 1'b0;
      // unused upper bits carry junk; the register must ignore them
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (value & keep) | (16'($urandom) & ~keep);
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic run_phase(input logic [1:0] bits, input logic [3:0] chans,
                            input logic [12:0] frames, input logic [15:0] limit,
                            input int budget, input int noise_pct);
      int          sent;
      int          nch;
      int          span;
      int          cut_at;
      int          flip_at;
      logic [31:0] mask;
      logic [31:0] lead [MAX_CHANNELS_DEF];
      logic [31:0] v;
      req_type     w;
      settle_gate();
      write_reg(CSR_SAMPLE_BITS, 16'(bits));
      write_reg(CSR_CHANNEL_COUNT, 16'(chans));
      write_reg(CSR_BLOCK_FRAMES, 16'(frames));
      write_reg(CSR_SILENCE_LIMIT, limit);
      nch = active_channels();
      span = nch * active_frames();
      mask = width_mask();
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            w.operation = ($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_SHORT;
            w.sample_value = $urandom;
            send_word(w, 1'b0, '0);
            sent++;
         end else begin
            cut_at = -1;
            if (span > 1 && $urandom_range(0, 99) < noise_pct)
               cut_at = $urandom_range(1, span - 1);
            flip_at = -1;
            if (span > nch && $urandom_range(0, 99) < 35)
               flip_at = $urandom_range(nch, span - 1);
            for (int pos = 0; pos < span; pos++) begin
               if (pos == cut_at) begin
                  w.operation = OP_SHORT;
                  w.sample_value = $urandom;
                  send_word(w, 1'b0, '0);
                  sent++;
                  break;
               end
               if (pos < nch) begin
                  v = pick_sample();
                  lead[pos] = v;
               end else begin
                  // same value at this width, junk above it
                  v = (lead[pos % nch] & mask) | ($urandom & ~mask);
                  if (pos == flip_at)
                     v = v ^ (32'h1 << $urandom_range(0, $countones(mask) - 1));
               end
               w.operation = OP_SAMPLE;
               w.sample_value = v;
               send_word(w, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // result side: check each popped word, stall on a changing pattern
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (gate_expect_q.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data);
            end else begin
               exp_r = gate_expect_q.pop_front();
               results_checked++;
               connects += exp_r.connect_event;
               disconnects += exp_r.disconnect_event;
               silent_seen += exp_r.block_silent;
               if (rsp_data.connect_event !== exp_r.connect_event
                   || rsp_data.disconnect_event !== exp_r.disconnect_event
                   || rsp_data.forward_block !== exp_r.forward_block
                   || rsp_data.block_silent !== exp_r.block_silent
                   || rsp_data.silence_count !== exp_r.silence_count
                   || rsp_data.halted !== exp_r.halted)
                  note_mismatch("result mismatch", exp_r, rsp_data);
            end
         end
         pop_tick <= pop_tick + 16'd1;
         if (pop_tick[5:0] == 6'd0) pop_mode = $urandom_range(0, 3);
         case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= pop_tick[1:0] != 2'd0;
            default: pop <= pop_tick[1:0] == 2'd0;
         endcase
      end
   end

   initial begin
      req_type w;
      gate_cfg.sample_bits_code = SAMPLE_BITS_RST;
      gate_cfg.channel_count = CHANNEL_COUNT_RST;
      gate_cfg.block_frames = BLOCK_FRAMES_RST;
      gate_cfg.silence_limit = SILENCE_LIMIT_RST;
      foreach (frame_ref[i]) frame_ref[i] = '0;
      frame_pos = 0;
      chan_pos = 0;
      diff_seen = 1'b0;
      silent_run = '0;
      linked = 1'b0;
      halted_flag = 1'b0;

      // fresh out of reset: nothing connected, so a short read reports all zero
      dir_rows.push_back(golden_row(OP_SHORT, 32'h0, '0));
      dir_rows.push_back(csr_row(CSR_SAMPLE_BITS, 16'(WIDTH_8)));
      dir_rows.push_back(csr_row(CSR_CHANNEL_COUNT, 16'd1));
      dir_rows.push_back(csr_row(CSR_BLOCK_FRAMES, 16'd2));
      dir_rows.push_back(csr_row(CSR_SILENCE_LIMIT, 16'd2));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_007F));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'hFFFF_FF7F));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h8000_0000));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0000));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0001));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0002));
      dir_rows.push_back(word_row(OP_UNUSED, 32'hFFFF_FFFF));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0001));
      dir_rows.push_back(word_row(OP_SHORT, 32'h0));
      dir_rows.push_back(csr_row(CSR_SAMPLE_BITS, 16'(WIDTH_24)));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0005));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_0005));
      dir_rows.push_back(csr_row(CSR_SAMPLE_BITS, 16'(WIDTH_32)));
      dir_rows.push_back(csr_row(CSR_CHANNEL_COUNT, 16'd0));
      dir_rows.push_back(csr_row(CSR_BLOCK_FRAMES, 16'd0));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h7FFF_FFFF));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h8000_0000));
      dir_rows.push_back(csr_row(CSR_SILENCE_LIMIT, 16'd0));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h1234_5678));
      // zero limit, already dropped: never reconnects, never forwards
      dir_rows.push_back(golden_row(OP_SAMPLE, 32'hA5A5_A5A5, '0));
      dir_rows.push_back(csr_row(CSR_SILENCE_LIMIT, 16'hFFFF));
      dir_rows.push_back(csr_row(CSR_CHANNEL_COUNT, 16'd3));
      dir_rows.push_back(csr_row(CSR_BLOCK_FRAMES, 16'd2));
      dir_rows.push_back(csr_row(CSR_SAMPLE_BITS, 16'(WIDTH_16)));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'hFFFF_8000));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0000_FFFF));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h7FFF_1234));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h0001_8000));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'hFFFF_FFFF));
      dir_rows.push_back(word_row(OP_SAMPLE, 32'h8000_1234));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle_gate();
            write_reg(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].golden);
         end
      end

      run_phase(WIDTH_8,  4'd1,  13'd2, 16'd1,     120, 8);
      run_phase(WIDTH_16, 4'd2,  13'd3, 16'd2,     120, 8);
      run_phase(WIDTH_32, 4'd3,  13'd2, 16'd3,     120, 8);
      run_phase(WIDTH_24, 4'd2,  13'd2, 16'd1,      80, 8);
      run_phase(WIDTH_8,  4'd15, 13'd2, 16'd2,     120, 6);
      run_phase(WIDTH_16, 4'd0,  13'd4, 16'd1,     100, 8);
      run_phase(WIDTH_32, 4'd1,  13'd0, 16'd2,      60, 8);
      run_phase(WIDTH_16, 4'd4,  13'd4, 16'd0,     100, 8);
      run_phase(WIDTH_8,  4'd1,  13'd5, 16'hFFFF,  100, 8);
      run_phase(WIDTH_16, 4'd8,  13'd1, 16'd3,      80, 8);
      repeat (4)
         run_phase(2'($urandom_range(0, 3)),
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 4)),
                   13'($urandom_range(0, 6)), 16'($urandom_range(0, 4)), 100, 8);

      // lose the device, then words that must be dropped
      w.operation = OP_SHORT;
      w.sample_value = $urandom;
      send_word(w, 1'b0, '0);
      w.operation = OP_LOST;
      w.sample_value = $urandom;
      send_word(w, 1'b0, '0);
      repeat (12) begin
         w.operation = 2'($urandom_range(0, 3));
         w.sample_value = $urandom;
         send_word(w, 1'b0, '0);
      end
      push <= 1'b0;

      for (int t = 0; t < 4000 && gate_expect_q.size() != 0; t++) @(posedge clock);
      if (gate_expect_q.size() != 0) begin
         $display("%0d results never arrived", gate_expect_q.size());
         mismatches += gate_expect_q.size();
      end
      repeat (8) @(posedge clock);

      $display("gate run: %0d words in, %0d results checked, %0d register writes",
               words_in, results_checked, reg_writes);
      $display("gate run: %0d connects, %0d disconnects, %0d silent blocks, %0d mismatches",
               connects, disconnects, silent_seen, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
